// File: hdl/assert_macros.svh
// Assertion helpers for the RTL, included by fir3_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is applied.
`define FIR3_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fir3 assertion failed");

// Next-cycle implication.
`define FIR3_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("fir3 assertion failed");

`endif

// File: hdl/fir3_pkg.sv
// ----------------------------------------------------------------------------
// fir3_pkg
// Shared constants, types and helpers of the three-channel FIR with beat rate.
// ----------------------------------------------------------------------------
package fir3_pkg;

	localparam int MAX_TAPS       = 64;
	localparam int WINDOW_LEN     = 100;
	localparam int COEF_FRAC_BITS = 15;

	localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TC_W     = 7;
	localparam int PS_DEPTH = 3 * MAX_TAPS;
	localparam int PS_AW    = $clog2(PS_DEPTH);
	localparam int WP_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int ACC_W    = 40;
	localparam int E_W      = 32;
	localparam int SUM_W    = 39;
	localparam int DIV_W    = 16;
	localparam int DIV_CW   = $clog2(DIV_W);
	localparam int CFG_W    = 39;

	// register indexes
	localparam logic [1:0] REG_TAP_COUNT  = 2'd0;
	localparam logic [1:0] REG_THRESHOLD  = 2'd1;
	localparam logic [1:0] REG_MIN_GAP    = 2'd2;
	localparam logic [1:0] REG_RATE_CONST = 2'd3;

	localparam logic [TC_W-1:0]  RST_TAP_COUNT  = 7'd1;
	localparam logic [SUM_W-1:0] RST_THRESHOLD  = 39'd17179869;
	localparam logic [15:0]      RST_MIN_GAP    = 16'd120;
	localparam logic [15:0]      RST_RATE_CONST = 16'd29100;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	typedef struct packed {
		logic              cap_in;
		logic              coef_wr;
		logic              tap_vld;
		logic [1:0]        tap_ch;
		logic [TAP_AW-1:0] tap_idx;
		logic              tap_has_next;
		logic              rnd;
		logic              e_sq;
		logic              e_upd;
		logic              div_step;
		logic              out_load;
	} fir3_cmd_t;

	typedef struct packed {
		logic            have_prev;
		logic            beat_now;
		logic            out_free;
		logic [TC_W-1:0] taps;
	} fir3_stat_t;

	function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		logic signed [ACC_W:0] r;
		t = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (COEF_FRAC_BITS - 1));
		r = t >>> COEF_FRAC_BITS;
		if (r > (ACC_W+1)'(32767))
			return 16'sh7FFF;
		else if (r < -(ACC_W+1)'(32768))
			return 16'sh8000;
		else
			return r[15:0];
	endfunction

endpackage

// File: hdl/three_channel_fir_with_beat_rate_unit.sv
// ----------------------------------------------------------------------------
// three_channel_fir_with_beat_rate_unit
// Three-channel transposed-form FIR with energy-window beat-rate detection.
// ----------------------------------------------------------------------------
// A single MAC pipeline walks every tap of every channel one per cycle (taps
// in use 1..64); then, from the second frame on, the energy update runs, and a
// one-bit-per-cycle divider for beats per minute runs when a beat is found. A
// coefficient write returns no transfer. A finished result sits in an output
// register, so the next frame is taken while it waits. Partial sums and the
// energy window come up cleared from reset through per-entry valid bits; no
// clearing pass is needed.
module three_channel_fir_with_beat_rate_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [1:0]                 cfg_index,
	input  logic [fir3_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic signed [15:0]         sample_ch0,
	input  logic signed [15:0]         sample_ch1,
	input  logic signed [15:0]         sample_ch2,
	input  logic [5:0]                 coef_index,
	input  logic signed [15:0]         coef_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [15:0]         filtered_ch0,
	output logic signed [15:0]         filtered_ch1,
	output logic signed [15:0]         filtered_ch2,
	output logic                       beat_found,
	output logic [15:0]                beats_per_minute
);

	fir3_pkg::fir3_cmd_t  cmd;
	fir3_pkg::fir3_stat_t stat;

	fir3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	fir3_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample_ch0       (sample_ch0),
		.sample_ch1       (sample_ch1),
		.sample_ch2       (sample_ch2),
		.coef_index       (coef_index),
		.coef_value       (coef_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.filtered_ch0     (filtered_ch0),
		.filtered_ch1     (filtered_ch1),
		.filtered_ch2     (filtered_ch2),
		.beat_found       (beat_found),
		.beats_per_minute (beats_per_minute)
	);

endmodule

// File: hdl/fir3_ctrl.sv
// ----------------------------------------------------------------------------
// fir3_ctrl
// Sequencer: tap issue over three channels, energy update, divide, output.
// ----------------------------------------------------------------------------
module fir3_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 req_type,
	output logic                 in_stall,
	input  fir3_pkg::fir3_stat_t stat,
	output fir3_pkg::fir3_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIR   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_RND   = 3'd3;
	localparam logic [2:0] S_ESQ   = 3'd4;
	localparam logic [2:0] S_EUPD  = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]                  state_q;
	logic [1:0]                  ch_q;
	logic [fir3_pkg::TAP_AW-1:0] tap_q;
	logic                        drain_q;
	logic [fir3_pkg::DIV_CW-1:0] div_cnt_q;
	logic                        last_tap;

	assign in_stall = (state_q != S_IDLE);
	assign last_tap = ({1'b0, tap_q} + 7'd1) >= stat.taps;

	always_comb begin
		cmd              = '0;
		cmd.tap_ch       = ch_q;
		cmd.tap_idx      = tap_q;
		cmd.tap_has_next = !last_tap;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.coef_wr = (req_type == fir3_pkg::REQ_COEF);
					cmd.cap_in  = (req_type == fir3_pkg::REQ_SAMPLE);
				end
			end
			S_FIR:  cmd.tap_vld  = 1'b1;
			S_RND:  cmd.rnd      = 1'b1;
			S_ESQ:  cmd.e_sq     = 1'b1;
			S_EUPD: cmd.e_upd    = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_FIN:  cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ch_q      <= '0;
			tap_q     <= '0;
			drain_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && req_type == fir3_pkg::REQ_SAMPLE) begin
						state_q <= S_FIR;
						ch_q    <= '0;
						tap_q   <= '0;
					end
				end
				S_FIR: begin
					if (last_tap) begin
						tap_q <= '0;
						if (ch_q == 2'd2) begin
							state_q <= S_DRAIN;
							drain_q <= 1'b0;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// wait out the read and multiply stages
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= S_RND;
				end
				S_RND: state_q <= stat.have_prev ? S_ESQ : S_FIN;
				S_ESQ: state_q <= S_EUPD;
				S_EUPD: begin
					div_cnt_q <= '0;
					state_q   <= stat.beat_now ? S_DIV : S_FIN;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == fir3_pkg::DIV_CW'(fir3_pkg::DIV_W - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/fir3_dp.sv
// ----------------------------------------------------------------------------
// fir3_dp
// Datapath: coefficient and partial-sum memories, shared MAC pipeline,
// energy window, restoring divider and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir3_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fir3_pkg::fir3_cmd_t               cmd,
	output fir3_pkg::fir3_stat_t              stat,
	input  logic                              cfg_write,
	input  logic [1:0]                        cfg_index,
	input  logic [fir3_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [15:0]                sample_ch0,
	input  logic signed [15:0]                sample_ch1,
	input  logic signed [15:0]                sample_ch2,
	input  logic [5:0]                        coef_index,
	input  logic signed [15:0]                coef_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                filtered_ch0,
	output logic signed [15:0]                filtered_ch1,
	output logic signed [15:0]                filtered_ch2,
	output logic                              beat_found,
	output logic [15:0]                       beats_per_minute
);

	// configuration
	logic [fir3_pkg::TC_W-1:0]  tap_count_q;
	logic [fir3_pkg::SUM_W-1:0] thresh_q;
	logic [15:0]                gap_q;
	logic [15:0]                rate_q;
	logic [fir3_pkg::TC_W-1:0]  taps;

	// memories
	logic signed [15:0]                coef_mem [fir3_pkg::MAX_TAPS];
	logic signed [fir3_pkg::ACC_W-1:0] ps_mem   [fir3_pkg::PS_DEPTH];
	logic [fir3_pkg::PS_DEPTH-1:0]     ps_vld_q;
	logic [fir3_pkg::E_W-1:0]          win_mem  [fir3_pkg::WINDOW_LEN];
	logic [fir3_pkg::WINDOW_LEN-1:0]   win_vld_q;

	// MAC pipeline
	logic signed [15:0]                x_q [3];
	logic                              vld_s1, vld_s2;
	logic [1:0]                        ch_s1, ch_s2;
	logic [fir3_pkg::TAP_AW-1:0]       idx_s1, idx_s2;
	logic                              nxt_s1;
	logic signed [15:0]                coef_s1;
	logic signed [fir3_pkg::ACC_W-1:0] psum_s1, psum_s2;
	logic signed [31:0]                prod_s2;
	logic signed [fir3_pkg::ACC_W-1:0] mac_sum;
	logic signed [fir3_pkg::ACC_W-1:0] acc_q [3];
	logic [fir3_pkg::PS_AW-1:0]        rd_addr, wr_addr;

	// energy and beat
	logic signed [15:0]         y_q [3];
	logic signed [15:0]         prev_q;
	logic                       have_prev_q;
	logic [fir3_pkg::E_W-1:0]   old_q, sq_q;
	logic [fir3_pkg::WP_W-1:0]  wp_q;
	logic [fir3_pkg::SUM_W-1:0] sum_q, sum_new;
	logic [15:0]                cnt_q;
	logic                       beat_q;
	logic signed [16:0]         diff;
	logic signed [33:0]         sq_full;

	// divider
	logic [16:0] rem_q, rem_sh;
	logic [15:0] quo_q, dvs_q;

	// output register
	logic        out_vld_q;
	logic [15:0] out_y0_q, out_y1_q, out_y2_q, out_bpm_q;
	logic        out_beat_q;

	always_comb begin
		if (tap_count_q == '0)
			taps = fir3_pkg::TC_W'(1);
		else if (tap_count_q > fir3_pkg::TC_W'(fir3_pkg::MAX_TAPS))
			taps = fir3_pkg::TC_W'(fir3_pkg::MAX_TAPS);
		else
			taps = tap_count_q;
	end

	assign stat.have_prev = have_prev_q;
	assign stat.out_free  = !out_vld_q || !out_stall;
	assign stat.taps      = taps;
	assign stat.beat_now  = (sum_new > thresh_q) && (cnt_q > gap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fir3_pkg::RST_TAP_COUNT;
			thresh_q    <= fir3_pkg::RST_THRESHOLD;
			gap_q       <= fir3_pkg::RST_MIN_GAP;
			rate_q      <= fir3_pkg::RST_RATE_CONST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fir3_pkg::REG_TAP_COUNT:  tap_count_q <= cfg_data[fir3_pkg::TC_W-1:0];
				fir3_pkg::REG_THRESHOLD:  thresh_q    <= cfg_data[fir3_pkg::SUM_W-1:0];
				fir3_pkg::REG_MIN_GAP:    gap_q       <= cfg_data[15:0];
				fir3_pkg::REG_RATE_CONST: rate_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// coefficient store
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && {1'b0, coef_index} < 7'(fir3_pkg::MAX_TAPS))
			coef_mem[coef_index[fir3_pkg::TAP_AW-1:0]] <= coef_value;
		if (cmd.tap_vld)
			coef_s1 <= coef_mem[cmd.tap_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			x_q[0] <= sample_ch0;
			x_q[1] <= sample_ch1;
			x_q[2] <= sample_ch2;
		end
	end

	// partial sums: read the next tap's old sum, write this tap's new sum
	assign rd_addr = fir3_pkg::PS_AW'(cmd.tap_ch) * fir3_pkg::PS_AW'(fir3_pkg::MAX_TAPS)
		+ fir3_pkg::PS_AW'({1'b0, cmd.tap_idx} + 1'b1);
	assign wr_addr = fir3_pkg::PS_AW'(ch_s2) * fir3_pkg::PS_AW'(fir3_pkg::MAX_TAPS)
		+ fir3_pkg::PS_AW'(idx_s2);
	assign mac_sum = fir3_pkg::ACC_W'(prod_s2) + psum_s2;

	always_ff @(posedge clk) begin
		if (cmd.tap_vld)
			psum_s1 <= ps_mem[rd_addr];
		if (vld_s2)
			ps_mem[wr_addr] <= mac_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			ps_vld_q <= '0;
		end else begin
			vld_s1 <= cmd.tap_vld;
			vld_s2 <= vld_s1;
			if (vld_s2)
				ps_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_vld) begin
			ch_s1  <= cmd.tap_ch;
			idx_s1 <= cmd.tap_idx;
			nxt_s1 <= cmd.tap_has_next && ps_vld_q[rd_addr];
		end
		if (vld_s1) begin
			ch_s2   <= ch_s1;
			idx_s2  <= idx_s1;
			prod_s2 <= coef_s1 * x_q[ch_s1];
			psum_s2 <= nxt_s1 ? psum_s1 : '0;
		end
		if (vld_s2 && idx_s2 == '0)
			acc_q[ch_s2] <= mac_sum;
	end

	// energy window
	assign diff    = {prev_q[15], prev_q} - {y_q[1][15], y_q[1]};
	assign sq_full = diff * diff;
	assign sum_new = sum_q - fir3_pkg::SUM_W'(old_q) + fir3_pkg::SUM_W'(sq_q);
	assign rem_sh  = {rem_q[15:0], quo_q[15]};

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			y_q[0] <= fir3_pkg::round_sat(acc_q[0]);
			y_q[1] <= fir3_pkg::round_sat(acc_q[1]);
			y_q[2] <= fir3_pkg::round_sat(acc_q[2]);
			old_q  <= win_vld_q[wp_q] ? win_mem[wp_q] : '0;
		end
		if (cmd.e_sq)
			sq_q <= sq_full[fir3_pkg::E_W-1:0];
		if (cmd.e_upd)
			win_mem[wp_q] <= sq_q;
		if (cmd.e_upd) begin
			rem_q <= '0;
			quo_q <= rate_q;
			dvs_q <= cnt_q;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			win_vld_q   <= '0;
			wp_q        <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			beat_q      <= 1'b0;
		end else begin
			if (cmd.cap_in)
				beat_q <= 1'b0;
			if (cmd.e_sq) begin
				prev_q <= y_q[1];
			end else if (cmd.rnd && !have_prev_q) begin
				prev_q      <= fir3_pkg::round_sat(acc_q[1]);
				have_prev_q <= 1'b1;
			end
			if (cmd.e_upd) begin
				sum_q           <= sum_new;
				win_vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == fir3_pkg::WP_W'(fir3_pkg::WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
				if (stat.beat_now) begin
					beat_q <= 1'b1;
					cnt_q  <= 16'd1;
				end else if (cnt_q != 16'hFFFF) begin
					cnt_q <= cnt_q + 16'd1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_y0_q   <= y_q[0];
			out_y1_q   <= y_q[1];
			out_y2_q   <= y_q[2];
			out_beat_q <= beat_q;
			out_bpm_q  <= beat_q ? quo_q : '0;
		end
	end

	assign out_valid        = out_vld_q;
	assign filtered_ch0     = out_y0_q;
	assign filtered_ch1     = out_y1_q;
	assign filtered_ch2     = out_y2_q;
	assign beat_found       = out_beat_q;
	assign beats_per_minute = out_bpm_q;

	`FIR3_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_vld_q || !out_stall))
	`FIR3_ASSERT_NEXT(a_beat_restart, cmd.e_upd && stat.beat_now, cnt_q == 16'd1 && beat_q)
	`FIR3_ASSERT(a_wp_range, cmd.e_upd |-> (wp_q < fir3_pkg::WP_W'(fir3_pkg::WINDOW_LEN)))

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the three-channel FIR with beat-rate unit against a cycle-free
// model of the filter, energy window and beat counter. Coefficients and
// sample frames stream in bursts, the output side stalls on its own pattern,
// and the registers change between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic               kind;
		logic signed [15:0] ch0;
		logic signed [15:0] ch1;
		logic signed [15:0] ch2;
		logic [5:0]         tap;
		logic signed [15:0] coef;
	} fir_req_t;

	typedef struct {
		logic signed [15:0] y0;
		logic signed [15:0] y1;
		logic signed [15:0] y2;
		logic               beat;
		logic [15:0]        bpm;
	} fir_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = fir3_pkg::REG_TAP_COUNT;
	logic [fir3_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = fir3_pkg::REQ_SAMPLE;
	logic signed [15:0] sample_ch0 = '0, sample_ch1 = '0, sample_ch2 = '0;
	logic [5:0] coef_index = '0;
	logic signed [15:0] coef_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] filtered_ch0, filtered_ch1, filtered_ch2;
	logic beat_found;
	logic [15:0] beats_per_minute;

	three_channel_fir_with_beat_rate_unit dut (.*);

	always #2 clk = ~clk;

	// filter model state
	logic [6:0]                        m_taps;
	logic [fir3_pkg::SUM_W-1:0]        m_threshold;
	logic [15:0]                       m_min_gap;
	logic [15:0]                       m_rate;
	logic signed [15:0]                m_coefs [fir3_pkg::MAX_TAPS];
	logic signed [fir3_pkg::ACC_W-1:0] m_psums [3][fir3_pkg::MAX_TAPS];
	logic signed [15:0]                m_prev_y1;
	logic                              m_have_prev;
	logic [fir3_pkg::E_W-1:0]          m_window [fir3_pkg::WINDOW_LEN];
	int                                m_wptr;
	logic [fir3_pkg::SUM_W-1:0]        m_energy;
	logic [15:0]                       m_count;

	fir_req_t    pending_reqs[$];
	fir_result_t expected_results[$];
	int          mismatches = 0;
	int          idle_cycles = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic signed [15:0] filter_channel(input int ch,
			input logic signed [15:0] x);
		int n;
		longint acc;
		n = (m_taps == 0) ? 1 :
			((m_taps > fir3_pkg::MAX_TAPS) ? fir3_pkg::MAX_TAPS : m_taps);
		for (int j = 0; j < n; j++) begin
			acc = longint'(m_coefs[j]) * longint'(x);
			if (j + 1 < n)
				acc += longint'(m_psums[ch][j + 1]);
			m_psums[ch][j] = acc[fir3_pkg::ACC_W-1:0];
		end
		acc = (longint'(m_psums[ch][0]) + (1 << (fir3_pkg::COEF_FRAC_BITS - 1)))
			>>> fir3_pkg::COEF_FRAC_BITS;
		if (acc > 32767)
			acc = 32767;
		if (acc < -32768)
			acc = -32768;
		return acc[15:0];
	endfunction

	task automatic predict_frame(input fir_req_t r);
		fir_result_t res;
		longint d;
		logic [fir3_pkg::E_W-1:0] e;
		if (r.kind == fir3_pkg::REQ_COEF) begin
			m_coefs[r.tap] = r.coef;
			return;
		end
		res.y0 = filter_channel(0, r.ch0);
		res.y1 = filter_channel(1, r.ch1);
		res.y2 = filter_channel(2, r.ch2);
		res.beat = 1'b0;
		res.bpm = '0;
		if (m_have_prev) begin
			d = longint'(m_prev_y1) - longint'(res.y1);
			e = fir3_pkg::E_W'(d * d);
			m_energy = m_energy - fir3_pkg::SUM_W'(m_window[m_wptr])
				+ fir3_pkg::SUM_W'(e);
			m_window[m_wptr] = e;
			m_wptr = (m_wptr + 1 >= fir3_pkg::WINDOW_LEN) ? 0 : m_wptr + 1;
			if (m_energy > m_threshold && m_count > m_min_gap) begin
				res.beat = 1'b1;
				res.bpm = m_rate / m_count;
				m_count = 16'd1;
			end else if (m_count != 16'hFFFF) begin
				m_count++;
			end
		end
		m_prev_y1 = res.y1;
		m_have_prev = 1'b1;
		expected_results.push_back(res);
	endtask

	// driver: bursts of transfers separated by random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		logic took;
		logic nv;
		took = 1'b0;
		nv = in_valid;
		if (in_valid && !in_stall) begin
			predict_frame(pending_reqs[0]);
			pending_reqs.delete(0);
			took = 1'b1;
		end
		if (!in_valid || took) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() > 0) begin
				nv = 1'b1;
				req_type <= pending_reqs[0].kind;
				sample_ch0 <= pending_reqs[0].ch0;
				sample_ch1 <= pending_reqs[0].ch1;
				sample_ch2 <= pending_reqs[0].ch2;
				coef_index <= pending_reqs[0].tap;
				coef_value <= pending_reqs[0].coef;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		in_valid <= nv;
	end

	// output stall pattern, switching between styles chosen at random
	int cyc = 0;
	logic [1:0] stall_mode = 2'd0;
	always @(posedge clk) begin
		cyc++;
		if (cyc % 256 == 0)
			stall_mode = 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 1) == 1);
			2'd2: out_stall <= (cyc[5:4] == 2'b11);
			default: out_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		fir_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (filtered_ch0 !== want.y0)
					report_mismatch($sformatf("filtered_ch0 %0d, want %0d", filtered_ch0, want.y0));
				if (filtered_ch1 !== want.y1)
					report_mismatch($sformatf("filtered_ch1 %0d, want %0d", filtered_ch1, want.y1));
				if (filtered_ch2 !== want.y2)
					report_mismatch($sformatf("filtered_ch2 %0d, want %0d", filtered_ch2, want.y2));
				if (beat_found !== want.beat)
					report_mismatch($sformatf("beat_found %0b, want %0b", beat_found, want.beat));
				if (beats_per_minute !== want.bpm)
					report_mismatch($sformatf("beats_per_minute %0d, want %0d",
						beats_per_minute, want.bpm));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [fir3_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			fir3_pkg::REG_TAP_COUNT: m_taps = val[6:0];
			fir3_pkg::REG_THRESHOLD: m_threshold = val[fir3_pkg::SUM_W-1:0];
			fir3_pkg::REG_MIN_GAP: m_min_gap = val[15:0];
			default: m_rate = val[15:0];
		endcase
	endtask

	task automatic set_phase(input logic [6:0] taps, input logic [fir3_pkg::CFG_W-1:0] thr,
			input logic [15:0] gap, input logic [15:0] rate);
		write_reg(fir3_pkg::REG_TAP_COUNT, fir3_pkg::CFG_W'(taps));
		write_reg(fir3_pkg::REG_THRESHOLD, thr);
		write_reg(fir3_pkg::REG_MIN_GAP, fir3_pkg::CFG_W'(gap));
		write_reg(fir3_pkg::REG_RATE_CONST, fir3_pkg::CFG_W'(rate));
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain;
		while (pending_reqs.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic push_frame(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic signed [15:0] c);
		fir_req_t r;
		r = '{fir3_pkg::REQ_SAMPLE, a, b, c, 6'($urandom()), 16'($urandom())};
		pending_reqs.push_back(r);
	endtask

	task automatic push_coef(input logic [5:0] idx, input logic signed [15:0] val);
		fir_req_t r;
		r = '{fir3_pkg::REQ_COEF, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			idx, val};
		pending_reqs.push_back(r);
	endtask

	function automatic logic signed [15:0] rand_sample(input int shape, input int k);
		case (shape)
			0: return 16'($urandom());
			1: return 16'($signed($urandom_range(0, 511)) - 256);
			default: return (k % 7 == 0) ? 16'($urandom_range(8000, 32767)) :
				16'($signed($urandom_range(0, 63)) - 32);
		endcase
	endfunction

	task automatic push_random(input int count);
		int shape;
		shape = $urandom_range(0, 2);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 8)
				push_coef(6'($urandom()), 16'($urandom()));
			else
				push_frame(rand_sample(shape, k), rand_sample(shape, k), rand_sample(shape, k));
			if (k % 40 == 39)
				shape = $urandom_range(0, 2);
		end
	endtask

	initial begin
		m_taps = fir3_pkg::RST_TAP_COUNT;
		m_threshold = fir3_pkg::RST_THRESHOLD;
		m_min_gap = fir3_pkg::RST_MIN_GAP;
		m_rate = fir3_pkg::RST_RATE_CONST;
		m_prev_y1 = '0;
		m_have_prev = 1'b0;
		m_wptr = 0;
		m_energy = '0;
		m_count = '0;
		foreach (m_coefs[i])
			m_coefs[i] = '0;
		foreach (m_psums[c, j])
			m_psums[c][j] = '0;
		foreach (m_window[i])
			m_window[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// tap count zero behaves as one tap; every coefficient gets loaded first
		set_phase(7'd0, '0, 16'd0, 16'd1);
		for (int i = 0; i < fir3_pkg::MAX_TAPS; i++)
			push_coef(6'(i), 16'($urandom()));
		push_coef(6'd0, 16'sh7FFF);
		push_frame(16'sh7FFF, 16'sh8000, 16'sh0000);
		push_frame(16'sh8000, 16'sh7FFF, 16'shFFFF);
		push_coef(6'd0, 16'sh8000);
		push_frame(16'sh8000, 16'sh8000, 16'sh7FFF);
		push_frame(16'sh0001, 16'sh7FFF, 16'sh8000);
		push_frame(16'sh0000, 16'sh0000, 16'sh0000);
		push_coef(6'd63, 16'sh8000);
		push_coef(6'd1, 16'sh4000);
		push_frame(16'sh5555, 16'shAAAA, 16'sh0001);
		push_random(150);
		drain();

		// taps saturate at the maximum, threshold and gap at their top
		set_phase(7'd127, {fir3_pkg::CFG_W{1'b1}}, 16'hFFFF, 16'hFFFF);
		push_frame(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		push_frame(16'sh8000, 16'sh8000, 16'sh8000);
		push_random(60);
		drain();

		// shrink, then grow again so stale partial sums come back into use
		set_phase(7'd3, fir3_pkg::CFG_W'(1000), 16'd5, 16'd29100);
		push_random(120);
		drain();
		set_phase(7'd64, fir3_pkg::CFG_W'(17179869), 16'd120, 16'd29100);
		push_random(60);
		drain();

		for (int p = 0; p < 9; p++) begin
			set_phase(7'($urandom_range(1, 12)),
				($urandom_range(0, 3) == 0) ? fir3_pkg::CFG_W'($urandom()) :
					fir3_pkg::CFG_W'($urandom_range(0, 1 << 20)),
				16'($urandom_range(0, 30)), 16'($urandom_range(1, 65535)));
			push_random(125);
			drain();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/fir3_pkg.sv
hdl/fir3_ctrl.sv
hdl/fir3_dp.sv
hdl/three_channel_fir_with_beat_rate_unit.sv
tb/sv/tb_top.sv
